// File: hdl/blg_pkg.sv
package blg_pkg;

  localparam int COORD_BITS = 10;
  localparam int COLOR_BITS = 16;
  localparam int ERR_BITS   = COORD_BITS + 2;

  typedef enum logic {
    OP_START   = 1'b0,
    OP_ADVANCE = 1'b1
  } blg_op_t;

  typedef struct packed {
    blg_op_t               opcode;
    logic [COORD_BITS-1:0] start_x;
    logic [COORD_BITS-1:0] start_y;
    logic [COORD_BITS-1:0] end_x;
    logic [COORD_BITS-1:0] end_y;
    logic [COLOR_BITS-1:0] line_color;
  } blg_in_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
    logic [COLOR_BITS-1:0] pixel_color;
    logic                  last_pixel;
  } blg_out_t;

  // queue head as seen by the engine
  typedef struct packed {
    logic    valid;
    blg_in_t word;
  } blg_head_t;

endpackage

// File: hdl/blg_queue.sv
module blg_queue #(
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  blg_pkg::blg_in_t in_word,
  output blg_pkg::blg_head_t head,
  input  logic             pop
);
  import blg_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  blg_in_t       slot_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          push;
  logic          do_pop;

  assign in_ready   = (count_r != FULL_CNT);
  assign push       = in_valid && in_ready;
  assign head.valid = (count_r != '0);
  assign head.word  = slot_r[rd_ptr_r];
  assign do_pop     = pop && head.valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push, do_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= in_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("queue count exceeds depth");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0 || count_r == FULL_CNT) |-> (wr_ptr_r == rd_ptr_r))
    else $error("queue pointers disagree with count");

endmodule

// File: hdl/blg_engine.sv
module blg_engine (
  input  logic               clk,
  input  logic               rst_n,
  input  blg_pkg::blg_head_t head,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output blg_pkg::blg_out_t  out_word
);
  import blg_pkg::*;

  localparam int E2_BITS = ERR_BITS + 1;

  logic [COORD_BITS-1:0] cur_x_r, cur_x_nxt, cur_y_r, cur_y_nxt;
  logic [COORD_BITS-1:0] tgt_x_r, tgt_x_nxt, tgt_y_r, tgt_y_nxt;
  logic [COORD_BITS-1:0] dx_r, dx_nxt, dy_r, dy_nxt;
  logic                  sxn_r, sxn_nxt, syn_r, syn_nxt;
  logic signed [ERR_BITS-1:0] err_r, err_nxt;
  logic [COLOR_BITS-1:0] color_r, color_nxt;
  logic                  busy_r, busy_nxt;
  logic                  out_valid_r;
  blg_out_t              out_word_r;

  logic                  res_valid;
  blg_out_t              res;
  logic signed [E2_BITS-1:0] e2, dx_s, dy_s;
  logic                  step_x, step_y;
  logic [COORD_BITS-1:0] nx, ny;
  logic                  x_lt, y_lt;
  logic [COORD_BITS-1:0] adx, ady;

  assign pop       = head.valid && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  assign x_lt = head.word.start_x < head.word.end_x;
  assign y_lt = head.word.start_y < head.word.end_y;
  assign adx  = x_lt ? head.word.end_x - head.word.start_x
                     : head.word.start_x - head.word.end_x;
  assign ady  = y_lt ? head.word.end_y - head.word.start_y
                     : head.word.start_y - head.word.end_y;

  assign e2     = {err_r, 1'b0};
  assign dx_s   = $signed({{(E2_BITS-COORD_BITS){1'b0}}, dx_r});
  assign dy_s   = $signed({{(E2_BITS-COORD_BITS){1'b0}}, dy_r});
  assign step_x = e2 > -dy_s;
  assign step_y = e2 < dx_s;
  assign nx     = step_x ? (sxn_r ? cur_x_r - 1'b1 : cur_x_r + 1'b1) : cur_x_r;
  assign ny     = step_y ? (syn_r ? cur_y_r - 1'b1 : cur_y_r + 1'b1) : cur_y_r;

  always_comb begin
    cur_x_nxt = cur_x_r;
    cur_y_nxt = cur_y_r;
    tgt_x_nxt = tgt_x_r;
    tgt_y_nxt = tgt_y_r;
    dx_nxt    = dx_r;
    dy_nxt    = dy_r;
    sxn_nxt   = sxn_r;
    syn_nxt   = syn_r;
    err_nxt   = err_r;
    color_nxt = color_r;
    busy_nxt  = busy_r;
    res_valid = 1'b0;
    res       = '0;
    if (pop) begin
      case (head.word.opcode)
        OP_START: begin
          cur_x_nxt = head.word.start_x;
          cur_y_nxt = head.word.start_y;
          tgt_x_nxt = head.word.end_x;
          tgt_y_nxt = head.word.end_y;
          dx_nxt    = adx;
          dy_nxt    = ady;
          sxn_nxt   = !x_lt;
          syn_nxt   = !y_lt;
          err_nxt   = $signed({2'b00, adx}) - $signed({2'b00, ady});
          color_nxt = head.word.line_color;
          busy_nxt  = (adx != '0) || (ady != '0);
          res_valid       = 1'b1;
          res.pixel_x     = head.word.end_x;
          res.pixel_y     = head.word.end_y;
          res.pixel_color = head.word.line_color;
          res.last_pixel  = (adx == '0) && (ady == '0);
        end
        default: begin
          if (busy_r) begin
            // emit current pixel, then take one step toward the end
            cur_x_nxt = nx;
            cur_y_nxt = ny;
            err_nxt   = err_r - (step_x ? $signed({2'b00, dy_r}) : ERR_BITS'(0))
                              + (step_y ? $signed({2'b00, dx_r}) : ERR_BITS'(0));
            busy_nxt  = !((nx == tgt_x_r) && (ny == tgt_y_r));
            res_valid       = 1'b1;
            res.pixel_x     = cur_x_r;
            res.pixel_y     = cur_y_r;
            res.pixel_color = color_r;
            res.last_pixel  = (nx == tgt_x_r) && (ny == tgt_y_r);
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_x_r     <= '0;
      cur_y_r     <= '0;
      tgt_x_r     <= '0;
      tgt_y_r     <= '0;
      dx_r        <= '0;
      dy_r        <= '0;
      sxn_r       <= 1'b0;
      syn_r       <= 1'b0;
      err_r       <= '0;
      color_r     <= '0;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cur_x_r <= cur_x_nxt;
      cur_y_r <= cur_y_nxt;
      tgt_x_r <= tgt_x_nxt;
      tgt_y_r <= tgt_y_nxt;
      dx_r    <= dx_nxt;
      dy_r    <= dy_nxt;
      sxn_r   <= sxn_nxt;
      syn_r   <= syn_nxt;
      err_r   <= err_nxt;
      color_r <= color_nxt;
      busy_r  <= busy_nxt;
      if (res_valid) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_word_r <= res;
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !pop)
    else $error("pending word would be overwritten");

  a_last_idles: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res.last_pixel) |=> !busy_r)
    else $error("generator still busy after last pixel");

  a_idle_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && head.word.opcode == OP_ADVANCE && !busy_r) |=> !out_valid_r)
    else $error("advance while idle produced a word");

endmodule

// File: hdl/bresenham_line_generator_core.sv
// Bresenham line generator. Send a start word (opcode 0) with both endpoints
// and a color: the end pixel comes out first, flagged last when the line is a
// single point. Each advance word (opcode 1) then yields the next pixel from
// the start toward the end, the end itself excluded; last_pixel marks the
// final one. An advance while no line is running yields nothing, and a start
// drops any running line. Words enter a small queue and are executed at one
// per cycle by the error-update stage unless the output stalls, so the block
// sustains one word per clock, passing each through the queue and then the
// output register; the compare-and-add on the error term sets that rate.
module bresenham_line_generator_core #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  blg_pkg::blg_in_t  in_word,
  output logic              out_valid,
  input  logic              out_ready,
  output blg_pkg::blg_out_t out_word
);
  import blg_pkg::*;

  blg_head_t head;
  logic      pop;

  blg_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_word  (in_word),
    .head     (head),
    .pop      (pop)
  );

  blg_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

endmodule
